// ----- rtl/luminance_mean_stdev_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the luma mean / deviation block
// Immediate-implication and next-cycle checks, clocked on clk and disabled in
// reset. They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LUMINANCE_MEAN_STDEV_ASSERT_SVH
`define LUMINANCE_MEAN_STDEV_ASSERT_SVH
`ifndef SYNTHESIS
`define LMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LMS_ASSERT_IMP(lbl, ante, cons, msg)
`define LMS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/lms_pkg.sv -----
// ----------------------------------------------------------------------------
// lms_pkg
// Types, widths and constants shared by the luma mean / deviation block.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int MAX_PIXELS = 1048576;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);   // pixel count
  localparam int LUMA_W     = 22;                       // 2126r+7152g+722b
  localparam int PSQ_W      = 2 * LUMA_W;               // luma squared
  localparam int SUM_W      = 42;
  localparam int SQS_W      = 63;
  localparam int PROD_W     = 84;                       // wide products
  localparam int MULB_W     = 42;                       // shift-add multiplier
  localparam int REM_W      = PROD_W + 1;
  localparam int QUO_W      = 31;                       // variance ratio <= 2^30
  localparam int ROOT_W     = 32;
  localparam int STEP_W     = 5;

  localparam logic [LUMA_W-1:0] COEF_R = LUMA_W'(2126);
  localparam logic [LUMA_W-1:0] COEF_G = LUMA_W'(7152);
  localparam logic [LUMA_W-1:0] COEF_B = LUMA_W'(722);

  localparam logic [PROD_W-1:0] LUMA_FULL    = PROD_W'(2550000);
  localparam logic [PROD_W-1:0] LUMA_FULL_SQ = PROD_W'(64'd6502500000000);

  localparam logic [ROOT_W-1:0] SQRT_TOP  = ROOT_W'(32'h4000_0000);
  localparam logic [QUO_W-1:0]  VAR_MAX   = QUO_W'(32'h4000_0000);
  localparam logic [QUO_W-1:0]  MEAN_ONE  = QUO_W'(65536);

  localparam logic [STEP_W-1:0] DIV_VAR_LAST  = STEP_W'(30);  // 31 quotient bits
  localparam logic [STEP_W-1:0] DIV_MEAN_LAST = STEP_W'(16);  // 17 quotient bits
  localparam logic [STEP_W-1:0] SQRT_LAST     = STEP_W'(15);  // 16 root bits

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [16:0] mean_level;
    logic [15:0] spread;
    logic [20:0] pixel_total;
    logic        overflowed;
  } res_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_MUL_NQ,      // count * square sum
    DP_MUL_SS,      // sum * sum
    DP_MUL_NN,      // count * count
    DP_MUL_DV,      // count^2 * full^2
    DP_MUL_NF,      // count * full
    DP_MUL_STEP,
    DP_KEEP_T1,
    DP_SUB_T1,
    DP_KEEP_T2,
    DP_DIV_VAR,
    DP_DIV_MEAN,
    DP_DIV_STEP,
    DP_SQRT_LOAD,
    DP_SQRT_STEP,
    DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic pipe_busy;
  } dp_stat_t;

endpackage

// ----- rtl/lms_datapath.sv -----
// ----------------------------------------------------------------------------
// lms_datapath
// Luma pipe and accumulators, shared shift-add multiplier, restoring divider,
// bit-pair square root and the result register.
// ----------------------------------------------------------------------------
`include "luminance_mean_stdev_assert.svh"

module lms_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lms_pkg::pix_t     in_pix,
  input  lms_pkg::dp_cmd_t  cmd,
  output lms_pkg::dp_stat_t stat,
  output lms_pkg::res_t     out_res
);
  import lms_pkg::*;

  // accumulators and pipe flags
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SQS_W-1:0]  sqs_r;
  logic              drop_r;
  logic              add1_r;
  logic              add2_r;

  // pipe payload
  logic [LUMA_W-1:0] luma1_r;
  logic [LUMA_W-1:0] luma2_r;
  logic [PSQ_W-1:0]  sq2_r;

  // back end
  logic [PROD_W-1:0] p_r;
  logic [PROD_W-1:0] a_r;
  logic [MULB_W-1:0] b_r;
  logic [PROD_W-1:0] t1_r;
  logic [MULB_W-1:0] t2_r;
  logic [REM_W-1:0]  rem_r;
  logic [PROD_W-1:0] den_r;
  logic [QUO_W-1:0]  quo_r;
  logic [QUO_W-1:0]  feed_r;
  logic [ROOT_W-1:0] sv_r;
  logic [ROOT_W-1:0] sres_r;
  logic [ROOT_W-1:0] sbit_r;
  res_t              res_r;

  logic [LUMA_W-1:0] luma_c;
  logic [PSQ_W-1:0]  sq_c;
  logic              can_add;
  logic [REM_W-1:0]  div_sh;
  logic              div_ge;
  logic [ROOT_W-1:0] sq_trial;

  assign luma_c = COEF_R * LUMA_W'(in_pix.red) + COEF_G * LUMA_W'(in_pix.green)
                + COEF_B * LUMA_W'(in_pix.blue);
  assign sq_c    = PSQ_W'(luma1_r) * PSQ_W'(luma1_r);
  assign can_add = cnt_r < CNT_W'(MAX_PIXELS);

  assign div_sh   = {rem_r[REM_W-2:0], feed_r[QUO_W-1]};
  assign div_ge   = div_sh >= {1'b0, den_r};
  assign sq_trial = sres_r + sbit_r;

  assign stat.mul_done  = (b_r == '0);
  assign stat.pipe_busy = add1_r | add2_r;
  assign out_res        = res_r;

  // counters and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      sqs_r  <= '0;
      drop_r <= 1'b0;
      add1_r <= 1'b0;
      add2_r <= 1'b0;
    end else begin
      add1_r <= cmd.take & can_add;
      add2_r <= add1_r;
      if (cmd.op == DP_OUT_LOAD) begin
        cnt_r  <= '0;
        sum_r  <= '0;
        sqs_r  <= '0;
        drop_r <= 1'b0;
      end else begin
        if (cmd.take) begin
          if (can_add) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            drop_r <= 1'b1;
          end
        end
        if (add2_r) begin
          sum_r <= sum_r + SUM_W'(luma2_r);
          sqs_r <= sqs_r + SQS_W'(sq2_r);
        end
      end
    end
  end

  // luma pipe payload
  always_ff @(posedge clk) begin
    luma1_r <= luma_c;
    luma2_r <= luma1_r;
    sq2_r   <= sq_c;
  end

  // frame-end arithmetic
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_MUL_NQ: begin
        p_r <= '0;
        a_r <= PROD_W'(sqs_r);
        b_r <= MULB_W'(cnt_r);
      end
      DP_MUL_SS: begin
        p_r <= '0;
        a_r <= PROD_W'(sum_r);
        b_r <= MULB_W'(sum_r);
      end
      DP_MUL_NN: begin
        p_r <= '0;
        a_r <= PROD_W'(cnt_r);
        b_r <= MULB_W'(cnt_r);
      end
      DP_MUL_DV: begin
        p_r <= '0;
        a_r <= LUMA_FULL_SQ;
        b_r <= t2_r;
      end
      DP_MUL_NF: begin
        p_r <= '0;
        a_r <= LUMA_FULL;
        b_r <= MULB_W'(cnt_r);
      end
      DP_MUL_STEP: begin
        if (b_r[0]) begin
          p_r <= p_r + a_r;
        end
        a_r <= a_r << 1;
        b_r <= b_r >> 1;
      end
      DP_KEEP_T1: t1_r <= p_r;
      DP_SUB_T1:  t1_r <= t1_r - p_r;          // N*Q - S*S, never negative
      DP_KEEP_T2: t2_r <= p_r[MULB_W-1:0];
      DP_DIV_VAR: begin
        // numerator * 2^32 over 31 quotient bits: preload num*2, feed zeros
        den_r  <= p_r;
        rem_r  <= {t1_r, 1'b0};
        feed_r <= '0;
        quo_r  <= '0;
      end
      DP_DIV_MEAN: begin
        // sum * 2^16 over 17 quotient bits: preload sum/2, feed sum lsb
        den_r  <= p_r;
        rem_r  <= REM_W'(sum_r >> 1);
        feed_r <= {sum_r[0], (QUO_W-1)'(0)};
        quo_r  <= '0;
      end
      DP_DIV_STEP: begin
        rem_r  <= div_ge ? (div_sh - {1'b0, den_r}) : div_sh;
        quo_r  <= {quo_r[QUO_W-2:0], div_ge};
        feed_r <= feed_r << 1;
      end
      DP_SQRT_LOAD: begin
        sv_r   <= ROOT_W'(quo_r);
        sres_r <= '0;
        sbit_r <= SQRT_TOP;
      end
      DP_SQRT_STEP: begin
        if (sv_r >= sq_trial) begin
          sv_r   <= sv_r - sq_trial;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      DP_OUT_LOAD: begin
        res_r.mean_level  <= quo_r[16:0];
        res_r.spread      <= sres_r[15:0];
        res_r.pixel_total <= cnt_r;
        res_r.overflowed  <= drop_r;
      end
      default: ;
    endcase
  end

  `LMS_ASSERT_IMP(lms_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_PIXELS), "pixel count past bound")
  `LMS_ASSERT_IMP(lms_var_range, cmd.op == DP_SQRT_LOAD, quo_r <= VAR_MAX, "variance ratio over 1/4")
  `LMS_ASSERT_IMP(lms_mean_range, cmd.op == DP_OUT_LOAD, quo_r <= MEAN_ONE, "mean above full scale")

endmodule

// ----- rtl/lms_ctrl.sv -----
// ----------------------------------------------------------------------------
// lms_ctrl
// Sequencer: takes pixels, then walks the frame-end multiply, divide and root
// steps and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "luminance_mean_stdev_assert.svh"

module lms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lms_pkg::dp_cmd_t  cmd,
  input  lms_pkg::dp_stat_t stat
);
  import lms_pkg::*;

  typedef enum logic [15:0] {
    S_ACC    = 16'h0001,
    S_DRAIN  = 16'h0002,
    S_RUN_NQ = 16'h0004,
    S_LD_SS  = 16'h0008,
    S_RUN_SS = 16'h0010,
    S_LD_NN  = 16'h0020,
    S_RUN_NN = 16'h0040,
    S_LD_DV  = 16'h0080,
    S_RUN_DV = 16'h0100,
    S_DIV_V  = 16'h0200,
    S_SQ_LD  = 16'h0400,
    S_SQRT   = 16'h0800,
    S_LD_NF  = 16'h1000,
    S_RUN_NF = 16'h2000,
    S_DIV_M  = 16'h4000,
    S_FIN    = 16'h8000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_ACC);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.take  = 1'b0;
    cmd.op    = DP_NOP;
    case (state_r)
      S_ACC: begin
        cmd.take = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.op    = DP_MUL_NQ;
          state_nxt = S_RUN_NQ;
        end
      end
      S_RUN_NQ: begin
        if (stat.mul_done) begin
          cmd.op    = DP_KEEP_T1;
          state_nxt = S_LD_SS;
        end else begin
          cmd.op = DP_MUL_STEP;
        end
      end
      S_LD_SS: begin
        cmd.op    = DP_MUL_SS;
        state_nxt = S_RUN_SS;
      end
      S_RUN_SS: begin
        if (stat.mul_done) begin
          cmd.op    = DP_SUB_T1;
          state_nxt = S_LD_NN;
        end else begin
          cmd.op = DP_MUL_STEP;
        end
      end
      S_LD_NN: begin
        cmd.op    = DP_MUL_NN;
        state_nxt = S_RUN_NN;
      end
      S_RUN_NN: begin
        if (stat.mul_done) begin
          cmd.op    = DP_KEEP_T2;
          state_nxt = S_LD_DV;
        end else begin
          cmd.op = DP_MUL_STEP;
        end
      end
      S_LD_DV: begin
        cmd.op    = DP_MUL_DV;
        state_nxt = S_RUN_DV;
      end
      S_RUN_DV: begin
        if (stat.mul_done) begin
          cmd.op    = DP_DIV_VAR;
          cnt_nxt   = '0;
          state_nxt = S_DIV_V;
        end else begin
          cmd.op = DP_MUL_STEP;
        end
      end
      S_DIV_V: begin
        cmd.op  = DP_DIV_STEP;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == DIV_VAR_LAST) begin
          state_nxt = S_SQ_LD;
        end
      end
      S_SQ_LD: begin
        cmd.op    = DP_SQRT_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = DP_SQRT_STEP;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == SQRT_LAST) begin
          state_nxt = S_LD_NF;
        end
      end
      S_LD_NF: begin
        cmd.op    = DP_MUL_NF;
        state_nxt = S_RUN_NF;
      end
      S_RUN_NF: begin
        if (stat.mul_done) begin
          cmd.op    = DP_DIV_MEAN;
          cnt_nxt   = '0;
          state_nxt = S_DIV_M;
        end else begin
          cmd.op = DP_MUL_STEP;
        end
      end
      S_DIV_M: begin
        cmd.op  = DP_DIV_STEP;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == DIV_MEAN_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait while an older result word is still held off
        if (!out_valid_r || !out_stall) begin
          cmd.op    = DP_OUT_LOAD;
          state_nxt = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == DP_OUT_LOAD) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LMS_ASSERT_NXT(lms_last_drains, in_valid && !in_stall && in_last, state_r == S_DRAIN, "last pixel did not start frame end")
  `LMS_ASSERT_IMP(lms_no_overwrite, out_valid_r && out_stall, cmd.op != DP_OUT_LOAD, "result overwritten while held")
  `LMS_ASSERT_IMP(lms_div_count, state_r == S_DIV_V, cnt_r <= DIV_VAR_LAST, "divider step count overrun")
  `LMS_ASSERT_NXT(lms_load_shows, cmd.op == DP_OUT_LOAD, out_valid_r && state_r == S_ACC, "result not presented")

endmodule

// ----- rtl/luminance_mean_stdev.sv -----
// ----------------------------------------------------------------------------
// luminance_mean_stdev - Rec. 709 luma mean and standard deviation per frame
// Throughput: one pixel word per cycle while a frame streams in.
// Frame end: after the last pixel the input stalls while the luma pipe drains,
//   the shift-add multiplier, the 31 + 17 step divider and the 16 step root
//   run, and while an older result word is still held off by out_stall.
// Reset: synchronous active-low rst_n clears the accumulators and sequencer.
// ----------------------------------------------------------------------------
//
// Each pixel gives an exact integer luma L = 2126r + 7152g + 722b (full scale
// 2550000). A two-stage pipe forms L and L*L and adds them into the sum and
// sum of squares; the count is bumped when the word is taken. Once the count
// reaches the bound, further pixels are dropped and flagged.
//
// On the last pixel the sequencer waits for the pipe to empty, then:
//   N*Q, S*S  -> numerator N*Q - S*S
//   N*N*full^2 -> denominator; divide num*2^32 / den (31 quotient bits)
//   integer square root (16 bit pairs) -> spread
//   S*2^16 / (N*full) (17 quotient bits) -> mean_level
// The result word goes to an output register and the accumulators clear, so
// the next frame can stream while the result waits for the consumer.

module luminance_mean_stdev (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lms_pkg::pix_t in_pix,
  output logic          out_valid,
  input  logic          out_stall,
  output lms_pkg::res_t out_res
);
  import lms_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_pix.last_pixel),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  lms_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .cmd     (cmd),
    .stat    (stat),
    .out_res (out_res)
  );

endmodule
